// File: rtl/bmss_pkg.sv
// ----------------------------------------------------------------------------
// bmss_pkg: shared types and constants for the boiler mode switch sequencer
// Mode codes, register indexes, reset values and the structs that pass
// between the sequencer core and the top level.
// ----------------------------------------------------------------------------
package bmss_pkg;

  typedef enum logic [1:0] {
    MODE_BREW      = 2'd0,
    MODE_VAPOUR    = 2'd1,
    MODE_SWITCHING = 2'd2
  } mode_t;

  localparam int unsigned TimeW     = 32;
  localparam int unsigned SetpointW = 11;
  localparam int unsigned DelayW    = 16;
  localparam int unsigned TimeoutW  = 16;
  localparam int unsigned CfgIndexW = 3;
  localparam int unsigned CfgDataW  = 16;
  // 65535 s * 1000 fits in 26 bits
  localparam int unsigned TimeoutMsW = 26;
  localparam int unsigned MsPerS     = 1000;

  localparam logic [CfgIndexW-1:0] RegBrewSetpoint  = 3'd0;
  localparam logic [CfgIndexW-1:0] RegSteamSetpoint = 3'd1;
  localparam logic [CfgIndexW-1:0] RegSwitchDelay   = 3'd2;
  localparam logic [CfgIndexW-1:0] RegSteamTimeout  = 3'd3;
  localparam logic [CfgIndexW-1:0] RegAutoReturn    = 3'd4;

  localparam logic [SetpointW-1:0] BrewSetpointRst  = 11'd930;
  localparam logic [SetpointW-1:0] SteamSetpointRst = 11'd1400;

  typedef struct packed {
    logic [SetpointW-1:0]  brew_temp;
    logic [SetpointW-1:0]  steam_temp;
    logic [DelayW-1:0]     switch_delay_ms;
    logic [TimeoutMsW-1:0] steam_timeout_ms;  // timeout already scaled to ms
    logic                  auto_return_enable;
  } cfg_t;

  typedef struct packed {
    mode_t                mode;
    logic [TimeW-1:0]     switch_start_ms;
    logic [TimeW-1:0]     steam_start_ms;
    logic [SetpointW-1:0] target;
  } state_t;

  typedef struct packed {
    logic [1:0]           boiler_mode;
    logic                 is_switching;
    logic [SetpointW-1:0] temp_target;
    logic                 ramp_started;
  } result_t;

endpackage

// File: rtl/bmss_in_if.sv
// ----------------------------------------------------------------------------
// bmss_in_if: input channel of the boiler mode switch sequencer
// Carries one timestamp and steam request per transaction.
// ----------------------------------------------------------------------------
interface bmss_in_if;
  logic                           valid;
  logic                           ready;
  logic [bmss_pkg::TimeW-1:0]     now_ms;
  logic                           steam_request;

  modport source (output valid, output now_ms, output steam_request, input ready);
  modport sink   (input valid, input now_ms, input steam_request, output ready);
endinterface

// File: rtl/bmss_out_if.sv
// ----------------------------------------------------------------------------
// bmss_out_if: result channel of the boiler mode switch sequencer
// Carries mode, switching flag, temperature target and ramp flag.
// ----------------------------------------------------------------------------
interface bmss_out_if;
  logic                           valid;
  logic                           ready;
  logic [1:0]                     boiler_mode;
  logic                           is_switching;
  logic [bmss_pkg::SetpointW-1:0] temp_target;
  logic                           ramp_started;

  modport source (output valid, output boiler_mode, output is_switching,
                  output temp_target, output ramp_started, input ready);
  modport sink   (input valid, input boiler_mode, input is_switching,
                  input temp_target, input ramp_started, output ready);
endinterface

// File: rtl/boiler_mode_switch_sequencer_unit.sv
// ----------------------------------------------------------------------------
// boiler_mode_switch_sequencer_unit: brew/steam mode sequencer
// An input transaction passes the input register, then step logic into the
// result register and the mode state. Throughput: one transaction per cycle
// unless downstream stalls; the single-step state update sets it.
// Reset: synchronous; clears both pipeline slots, mode to brew, start times to
// zero, target to the brew default and the config registers to their defaults.
// ----------------------------------------------------------------------------
module boiler_mode_switch_sequencer_unit (
  input  logic                              clk,
  input  logic                              rst,
  bmss_in_if.sink                           tick,
  bmss_out_if.source                        result,
  input  logic                              cfg_we,
  input  logic [bmss_pkg::CfgIndexW-1:0]    cfg_index,
  input  logic [bmss_pkg::CfgDataW-1:0]     cfg_wdata
);

  // --------------------------------------------------------------------------
  // Configuration registers. The steam timeout is held in milliseconds so the
  // step logic compares instead of dividing; scale it once at write time.
  // --------------------------------------------------------------------------
  bmss_pkg::cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.brew_temp          <= bmss_pkg::BrewSetpointRst;
      cfg.steam_temp         <= bmss_pkg::SteamSetpointRst;
      cfg.switch_delay_ms    <= '0;
      cfg.steam_timeout_ms   <= '0;
      cfg.auto_return_enable <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        bmss_pkg::RegBrewSetpoint:  cfg.brew_temp  <= cfg_wdata[bmss_pkg::SetpointW-1:0];
        bmss_pkg::RegSteamSetpoint: cfg.steam_temp <= cfg_wdata[bmss_pkg::SetpointW-1:0];
        bmss_pkg::RegSwitchDelay:   cfg.switch_delay_ms <= cfg_wdata;
        bmss_pkg::RegSteamTimeout: begin
          cfg.steam_timeout_ms <= bmss_pkg::TimeoutMsW'(cfg_wdata) *
                                  bmss_pkg::TimeoutMsW'(bmss_pkg::MsPerS);
        end
        bmss_pkg::RegAutoReturn:    cfg.auto_return_enable <= cfg_wdata[0];
        default: begin
          // indexes beyond the register list are dropped
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline control. Stage 1 holds the accepted transaction; the result
  // register frees up when downstream takes it, so both stages advance
  // together and a new transaction enters every cycle when nothing stalls.
  // --------------------------------------------------------------------------
  logic                          s1_valid;
  logic [bmss_pkg::TimeW-1:0]    s1_now_ms;
  logic                          s1_steam_request;
  logic                          res_valid;
  bmss_pkg::result_t             res;
  logic                          res_ready;
  logic                          step_fire;
  logic                          tick_fire;

  assign res_ready  = !res_valid || result.ready;
  assign step_fire  = s1_valid && res_ready;
  assign tick.ready = !s1_valid || res_ready;
  assign tick_fire  = tick.valid && tick.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (tick.ready) begin
      s1_valid <= tick.valid;
    end
  end

  // payload: capture only on a transaction
  always_ff @(posedge clk) begin
    if (tick_fire) begin
      s1_now_ms        <= tick.now_ms;
      s1_steam_request <= tick.steam_request;
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer state and step logic. State advances only when stage 1 moves
  // into the result register, so a stall never replays a step.
  // --------------------------------------------------------------------------
  bmss_pkg::state_t  state;
  bmss_pkg::state_t  state_next;
  bmss_pkg::result_t step_res;

  bmss_step u_step (
    .cfg           (cfg),
    .state         (state),
    .now_ms        (s1_now_ms),
    .steam_request (s1_steam_request),
    .state_next    (state_next),
    .result        (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state.mode            <= bmss_pkg::MODE_BREW;
      state.switch_start_ms <= '0;
      state.steam_start_ms  <= '0;
      state.target          <= bmss_pkg::BrewSetpointRst;
    end else if (step_fire) begin
      state <= state_next;
    end
  end

  // result register: hold while downstream stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_ready) begin
      res_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step_fire) begin
      res <= step_res;
    end
  end

  assign result.valid        = res_valid;
  assign result.boiler_mode  = res.boiler_mode;
  assign result.is_switching = res.is_switching;
  assign result.temp_target  = res.temp_target;
  assign result.ramp_started = res.ramp_started;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_rst_clears: assert property (@(posedge clk)
    rst |=> !s1_valid && !res_valid)
    else $error("pipeline not empty after reset");

  a_s1_holds: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !res_ready) |=> s1_valid && $stable(s1_now_ms) &&
                                 $stable(s1_steam_request))
    else $error("stage 1 transaction lost during stall");

  a_state_idle: assert property (@(posedge clk) disable iff (rst)
    !step_fire |=> $stable(state))
    else $error("sequencer state moved without a step");

  a_target_ramp: assert property (@(posedge clk) disable iff (rst)
    (step_fire && !step_res.ramp_started) |=> $stable(state.target))
    else $error("temperature target changed without a ramp");

endmodule

// File: rtl/bmss_step.sv
// ----------------------------------------------------------------------------
// bmss_step: one sequencer step
// Request check, settle check and auto-return check in that order.
// ----------------------------------------------------------------------------
module bmss_step (
  input  bmss_pkg::cfg_t                cfg,
  input  bmss_pkg::state_t              state,
  input  logic [bmss_pkg::TimeW-1:0]    now_ms,
  input  logic                          steam_request,
  output bmss_pkg::state_t              state_next,
  output bmss_pkg::result_t             result
);

  logic ramp;

  always_comb begin
    bmss_pkg::state_t s;
    logic [bmss_pkg::TimeW-1:0] elapsed_switch;
    logic [bmss_pkg::TimeW-1:0] elapsed_steam;
    s    = state;
    ramp = 1'b0;

    // enter switching on a change of request
    if (steam_request && s.mode != bmss_pkg::MODE_VAPOUR &&
        s.mode != bmss_pkg::MODE_SWITCHING) begin
      s.mode            = bmss_pkg::MODE_SWITCHING;
      s.switch_start_ms = now_ms;
      s.steam_start_ms  = now_ms;
      s.target          = cfg.steam_temp;
      ramp              = 1'b1;
    end else if (!steam_request && s.mode == bmss_pkg::MODE_VAPOUR) begin
      s.mode            = bmss_pkg::MODE_SWITCHING;
      s.switch_start_ms = now_ms;
      s.target          = cfg.brew_temp;
      ramp              = 1'b1;
    end

    // settle once the delay has run out
    elapsed_switch = now_ms - s.switch_start_ms;
    if (s.mode == bmss_pkg::MODE_SWITCHING &&
        elapsed_switch >= {16'd0, cfg.switch_delay_ms}) begin
      s.mode = steam_request ? bmss_pkg::MODE_VAPOUR : bmss_pkg::MODE_BREW;
    end

    // whole seconds >= T is the same as milliseconds >= T * 1000
    elapsed_steam = now_ms - s.steam_start_ms;
    if (s.mode == bmss_pkg::MODE_VAPOUR && cfg.auto_return_enable &&
        cfg.steam_timeout_ms != '0 &&
        elapsed_steam >= {6'd0, cfg.steam_timeout_ms}) begin
      s.mode            = bmss_pkg::MODE_SWITCHING;
      s.switch_start_ms = now_ms;
      s.target          = cfg.brew_temp;
      ramp              = 1'b1;
    end

    state_next = s;
  end

  always_comb begin
    result.boiler_mode  = state_next.mode;
    result.is_switching = (state_next.mode == bmss_pkg::MODE_SWITCHING);
    result.temp_target  = state_next.target;
    result.ramp_started = ramp;
  end

endmodule
